FILE: hw/rtl/sbq_pkg.sv
// Shared types, widths, coefficient table and saturation helpers for the
// selectable biquad ECG filter. No dependencies; every other RTL file
// imports this package.
package sbq_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int STATE_WIDTH    = 24;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_WIDTH     = COEF_FRAC_BITS + 4;
  localparam int PROD_WIDTH     = COEF_WIDTH + STATE_WIDTH;
  localparam int ACC_WIDTH      = PROD_WIDTH + 2;
  localparam int RND_WIDTH      = ACC_WIDTH - COEF_FRAC_BITS;
  localparam int SET_SEL_WIDTH  = 3;
  localparam int NUM_SETS       = 8;
  localparam int NUM_TERMS      = 6;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILTER_KIND = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RATE_SELECT = 1'b1;

  localparam logic       FILTER_KIND_RESET = 1'b0;
  localparam logic [1:0] RATE_SELECT_RESET = 2'd1;

  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [STATE_WIDTH-1:0]  state_val_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [RND_WIDTH-1:0]    rnd_t;

  // Coefficient slots of one set. The feedback terms are stored already
  // negated, so every product is simply added.
  typedef enum logic [2:0] {
    TERM_G  = 3'd0,
    TERM_A1 = 3'd1,
    TERM_A2 = 3'd2,
    TERM_B0 = 3'd3,
    TERM_B1 = 3'd4,
    TERM_B2 = 3'd5
  } term_t;

  // Control from the sequencer to the shared multiply-accumulate unit.
  typedef struct packed {
    logic issue;
    logic first;
  } mac_ctrl_t;

  // Rounding bias: adding one half LSB before the floor shift.
  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
    ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

  // Q4.14 coefficients, row = kind*4 + rate, columns g, -a1, -a2, b0, b1, b2.
  localparam coef_t COEF_ROM [NUM_SETS][NUM_TERMS] = '{
    '{ 18'sd16384,   18'sd3018,  -18'sd2909,  18'sd4069,   18'sd8138,  18'sd4069 },
    '{ 18'sd16384,  18'sd20065,  -18'sd7380,   18'sd925,   18'sd1850,   18'sd925 },
    '{ 18'sd16384,  18'sd26282, -18'sd10985,   18'sd272,    18'sd543,   18'sd272 },
    '{ 18'sd16384,  18'sd29502, -18'sd13415,    18'sd74,    18'sd149,    18'sd74 },
    '{ 18'sd124973, -18'sd32768, -18'sd16384, 18'sd5578, -18'sd11156,  18'sd5578 },
    '{ 18'sd16384,   18'sd3018,  -18'sd2909, 18'sd10957, -18'sd21914, 18'sd10957 },
    '{ 18'sd16384,  18'sd26282, -18'sd10985, 18'sd13413, -18'sd26825, 18'sd13413 },
    '{ 18'sd16384,  18'sd29502, -18'sd13415, 18'sd14825, -18'sd29650, 18'sd14825 }
  };

  function automatic coef_t coef_lookup(input logic [SET_SEL_WIDTH-1:0] set_sel,
                                        input term_t term);
    coef_t c;
    unique case (term)
      TERM_G:  c = COEF_ROM[set_sel][0];
      TERM_A1: c = COEF_ROM[set_sel][1];
      TERM_A2: c = COEF_ROM[set_sel][2];
      TERM_B0: c = COEF_ROM[set_sel][3];
      TERM_B1: c = COEF_ROM[set_sel][4];
      TERM_B2: c = COEF_ROM[set_sel][5];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic state_val_t sat_state(input rnd_t v);
    logic [RND_WIDTH-STATE_WIDTH:0] top_bits;
    state_val_t r;
    top_bits = v[RND_WIDTH-1:STATE_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      r = v[STATE_WIDTH-1:0];
    end else if (v[RND_WIDTH-1]) begin
      r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic sample_t sat_sample(input rnd_t v);
    logic [RND_WIDTH-SAMPLE_WIDTH:0] top_bits;
    sample_t r;
    top_bits = v[RND_WIDTH-1:SAMPLE_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      r = v[SAMPLE_WIDTH-1:0];
    end else if (v[RND_WIDTH-1]) begin
      r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sbq_sample_if.sv
// Valid/ready channel that carries one raw input sample.
// Depends on sbq_pkg for the sample type.
interface sbq_sample_if;
  import sbq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/sbq_result_if.sv
// Valid/ready channel that carries one filtered output sample.
// Depends on sbq_pkg for the sample type.
interface sbq_result_if;
  import sbq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

FILE: hw/rtl/sbq_mac.sv
// Shared multiply-accumulate unit: a registered 18x24 product feeding an
// exact accumulator with round-half-up bias. Depends on sbq_pkg.
module sbq_mac
  import sbq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mac_ctrl_t  ctrl,
  input  coef_t      coef,
  input  state_val_t opnd,
  output rnd_t       rounded
);

  logic signed [PROD_WIDTH-1:0] prod;
  logic                         prod_valid;
  logic                         prod_first;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  acc_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
    prod_first <= ctrl.first;
    prod       <= coef * opnd;
  end

  // The first term of a sum starts from the rounding bias.
  assign acc_base = prod_first ? ROUND_BIAS : acc;

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= acc_base + ACC_WIDTH'(prod);
    end
  end

  // Floor shift of the biased sum gives the rounded result.
  assign rounded = acc[ACC_WIDTH-1:COEF_FRAC_BITS];

endmodule

FILE: hw/rtl/sbq_seq.sv
// Sequencer: configuration registers, the two delay values and the state
// machine that feeds six products to the shared MAC. Depends on sbq_pkg.
module sbq_seq
  import sbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sample_t                    in_sample,
  output logic                       y_valid,
  input  logic                       y_ready,
  output sample_t                    y_value,
  output mac_ctrl_t                  mac_ctrl,
  output coef_t                      mac_coef,
  output state_val_t                 mac_opnd,
  input  rnd_t                       mac_rounded
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FB    = 7'b0000010,
    ST_FF1   = 7'b0000100,
    ST_FF2   = 7'b0001000,
    ST_FF3   = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] fb_cnt;
  logic       filter_kind;
  logic [1:0] rate_select;
  state_val_t delay_first;
  state_val_t delay_second;
  state_val_t x_val;
  state_val_t w_val;
  term_t      term;

  assign in_ready = (state == ST_IDLE);
  assign y_valid  = (state == ST_DONE);
  assign y_value  = sat_sample(mac_rounded);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_FB;
      ST_FB:    if (fb_cnt == 2'd2) state_next = ST_FF1;
      ST_FF1:   state_next = ST_FF2;
      ST_FF2:   state_next = ST_FF3;
      ST_FF3:   state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (y_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Operand and coefficient selection for the product issued this cycle.
  always_comb begin
    mac_ctrl = '0;
    term     = TERM_G;
    mac_opnd = x_val;
    unique case (state)
      ST_FB: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.first = (fb_cnt == 2'd0);
        unique case (fb_cnt)
          2'd0:    begin term = TERM_G;  mac_opnd = x_val;        end
          2'd1:    begin term = TERM_A1; mac_opnd = delay_first;  end
          default: begin term = TERM_A2; mac_opnd = delay_second; end
        endcase
      end
      ST_FF1: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.first = 1'b1;
        term           = TERM_B1;
        mac_opnd       = delay_first;
      end
      ST_FF2: begin
        mac_ctrl.issue = 1'b1;
        term           = TERM_B2;
        mac_opnd       = delay_second;
      end
      ST_FF3: begin
        mac_ctrl.issue = 1'b1;
        term           = TERM_B0;
        mac_opnd       = w_val;
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  assign mac_coef = coef_lookup({filter_kind, rate_select}, term);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fb_cnt       <= '0;
      filter_kind  <= FILTER_KIND_RESET;
      rate_select  <= RATE_SELECT_RESET;
      delay_first  <= '0;
      delay_second <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FB) begin
        fb_cnt <= fb_cnt + 2'd1;
      end else begin
        fb_cnt <= '0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FILTER_KIND: filter_kind <= cfg_data[0];
          CFG_RATE_SELECT: rate_select <= cfg_data[1:0];
          default:         filter_kind <= filter_kind;
        endcase
        delay_first  <= '0;
        delay_second <= '0;
      end else if ((state == ST_DONE) && y_ready) begin
        delay_second <= delay_first;
        delay_first  <= w_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_val <= STATE_WIDTH'(in_sample);
    end
    // The feedback sum is complete in the accumulator during ST_FF2.
    if (state == ST_FF2) begin
      w_val <= sat_state(mac_rounded);
    end
  end

endmodule

FILE: hw/rtl/selectable_biquad_ecg_filter.sv
// Top level of the selectable biquad ECG filter: sequencer, shared MAC
// and output register. Depends on sbq_pkg, sbq_sample_if, sbq_result_if,
// sbq_mac and sbq_seq.
//
// Usage: raw samples arrive on the samples channel and filtered samples
// leave on the results channel; each is a valid/ready channel and a
// transfer happens on a clock edge with valid and ready both high.
// The configuration port writes filter_kind (index 0) or rate_select
// (index 1) with cfg_write; any such write also clears both delay values.
// Write configuration only while the filter is idle.
//
// One sample is worked on at a time. Six products go through the single
// 18x24 multiply-accumulate unit, whose product and accumulator stages are
// both registered, so a sample occupies the sequencer from its transfer
// until the output register takes its result, and no new sample is taken
// before then. The result lands in the output register as ST_DONE ends.
// The output register lets the next sample be taken while a result waits;
// if the receiver keeps stalling, the sequencer holds its finished result
// and does not advance the delays until the output register frees up.
// Reset (synchronous, active high) selects the 250 Hz lowpass set, clears
// both delays and empties the output register.
module selectable_biquad_ecg_filter
  import sbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  sbq_sample_if.sink                 samples,
  sbq_result_if.source               results
);

  mac_ctrl_t  mac_ctrl;
  coef_t      mac_coef;
  state_val_t mac_opnd;
  rnd_t       mac_rounded;
  logic       y_valid;
  logic       y_ready;
  sample_t    y_value;
  logic       out_valid;
  sample_t    out_filtered;

  sbq_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .in_sample   (samples.sample),
    .y_valid     (y_valid),
    .y_ready     (y_ready),
    .y_value     (y_value),
    .mac_ctrl    (mac_ctrl),
    .mac_coef    (mac_coef),
    .mac_opnd    (mac_opnd),
    .mac_rounded (mac_rounded)
  );

  sbq_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .coef    (mac_coef),
    .opnd    (mac_opnd),
    .rounded (mac_rounded)
  );

  // The output register takes a new result when it is empty or when its
  // current result is transferred in the same cycle.
  assign y_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (y_ready) begin
      out_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (y_valid && y_ready) begin
      out_filtered <= y_value;
    end
  end

  assign results.valid    = out_valid;
  assign results.filtered = out_filtered;

endmodule

FILE: hw/rtl/sbq_check.sv
// Port-level assertion checker for the selectable biquad ECG filter and
// the bind that attaches it to the top level. Depends on sbq_pkg.
module sbq_check
  import sbq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t filtered
);

  // Right after reset the filter is idle with no result pending.
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (in_ready && !out_valid))
    else $error("filter not idle and empty after reset");

  // A sample keeps the filter busy for several cycles after its transfer.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready ##1 !in_ready))
    else $error("filter accepted a sample while still working");

  // A stalled result stays put until it is transferred.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(filtered)))
    else $error("stalled result changed or vanished");

  // A new result only appears while the filter was busy on a sample.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the filter was idle");

endmodule

bind selectable_biquad_ecg_filter sbq_check u_sbq_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .filtered  (results.filtered)
);

FILE: sim/sbq_filter_checker.sv
// Self-checking monitor for the selectable biquad ECG filter: tracks the
// configuration writes, predicts every filtered sample and compares it with the
// output channel. Depends on sbq_pkg, sbq_sample_if and sbq_result_if.
module sbq_filter_checker
  import sbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  sbq_sample_if                      samples,
  sbq_result_if                      results,
  output int                         mismatches,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DESIGN_UNIT = 100000000;
  localparam int     REPORT_LIMIT = 10;

  // Filter design values in units of 1e-8: b0, b1, b2, a0, a1, a2.
  // Row = kind*4 + rate.
  localparam longint DESIGN_COEF [8][6] = '{
    '{ 24834108,   49668216, 24834108, DESIGN_UNIT,  -18421380, 17757812 },
    '{  5644846,   11289692,  5644846, DESIGN_UNIT, -122465158, 45044543 },
    '{  1658193,    3316386,  1658193, DESIGN_UNIT, -160413018, 67045791 },
    '{   453622,     907244,   453622, DESIGN_UNIT, -180064506, 81878993 },
    '{ 34044798,  -68089596, 34044798,    13110000,   26220000, 13110000 },
    '{ 66877425, -133754851, 66877425, DESIGN_UNIT,  -18421380, 17757812 },
    '{ 81864702, -163729404, 81864702, DESIGN_UNIT, -160413018, 67045791 },
    '{ 90485875, -180971749, 90485875, DESIGN_UNIT, -180064506, 81878993 }
  };

  logic       kind;
  logic [1:0] rate;
  state_val_t w_first;
  state_val_t w_second;
  sample_t    expected_filtered [$];

  // Scale num/den to Q4.14, rounding half away from zero.
  function automatic longint quantize_coef(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << COEF_FRAC_BITS) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Drop the fraction bits, rounding half toward +infinity.
  function automatic longint round_q14(input longint acc);
    return (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clip(input longint v, input int width);
    longint lim;
    lim = longint'(1) << (width - 1);
    if (v > lim - 1) begin
      return lim - 1;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // One direct form II step; advances the delay line.
  function automatic sample_t step_filter(input sample_t x);
    logic [2:0] sel;
    longint     a0;
    longint     acc;
    longint     w;
    longint     y;
    sel = {kind, rate};
    a0  = DESIGN_COEF[sel][3];
    acc = quantize_coef(DESIGN_UNIT, a0) * longint'(x)
        - quantize_coef(DESIGN_COEF[sel][4], a0) * longint'(w_first)
        - quantize_coef(DESIGN_COEF[sel][5], a0) * longint'(w_second);
    w   = clip(round_q14(acc), STATE_WIDTH);
    acc = quantize_coef(DESIGN_COEF[sel][0], DESIGN_UNIT) * w
        + quantize_coef(DESIGN_COEF[sel][1], DESIGN_UNIT) * longint'(w_first)
        + quantize_coef(DESIGN_COEF[sel][2], DESIGN_UNIT) * longint'(w_second);
    y   = clip(round_q14(acc), SAMPLE_WIDTH);
    w_second = w_first;
    w_first  = state_val_t'(w);
    return sample_t'(y);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Results are checked before the configuration and the new sample of the
  // same edge are taken in, since a result never belongs to either.
  always @(posedge clk) begin
    if (rst) begin
      kind     = FILTER_KIND_RESET;
      rate     = RATE_SELECT_RESET;
      w_first  = '0;
      w_second = '0;
      expected_filtered.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (expected_filtered.size() == 0) begin
          note_mismatch($sformatf("unexpected filtered sample %0d", results.filtered));
        end else if (results.filtered !== expected_filtered[0]) begin
          note_mismatch($sformatf("filtered expected %0d, got %0d",
                                  expected_filtered[0], results.filtered));
          void'(expected_filtered.pop_front());
        end else begin
          void'(expected_filtered.pop_front());
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_FILTER_KIND) begin
          kind = cfg_data[0];
        end else if (cfg_index == CFG_RATE_SELECT) begin
          rate = cfg_data[1:0];
        end
        w_first  = '0;
        w_second = '0;
      end
      if (samples.valid && samples.ready) begin
        expected_filtered.push_back(step_filter(samples.sample));
      end
    end
    outstanding = expected_filtered.size();
  end

endmodule

FILE: sim/tb_selectable_biquad_ecg_filter.sv
// Top-level testbench of the selectable biquad ECG filter: clock, reset,
// sample and configuration stimulus, and the verdict. Depends on sbq_pkg,
// both channel interfaces, the filter RTL and sbq_filter_checker.
module tb_selectable_biquad_ecg_filter;
  import sbq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register codes for the configuration port.
  localparam logic       KIND_LOWPASS  = 1'b0;
  localparam logic       KIND_HIGHPASS = 1'b1;
  localparam logic [1:0] RATE_100HZ    = 2'd0;
  localparam logic [1:0] RATE_1000HZ   = 2'd3;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Roughly 650 samples plus stalls stay well inside this cycle limit,
  // so it leaves a wide margin.
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_CYCLES     = 150;
  localparam int TAIL_CYCLES     = 30;
  localparam int ITEMS_PER_SET   = 50;
  localparam int SETS_PER_PHASE  = 4;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  sbq_sample_if smp ();
  sbq_result_if res ();

  int   mismatches;
  int   outstanding;
  int   cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_ready;

  selectable_biquad_ecg_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp),
    .results   (res)
  );

  sbq_filter_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples     (smp),
    .results     (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The cycle counter ends a run that hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver drives ready at every falling edge. While hold_ready is set
  // it refuses every transfer, which fills the output register and then
  // backs up into the sample channel.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ready || rst) begin
        res.ready = 1'b0;
      end else begin
        res.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one sample, starting at a falling edge, and returns at the falling
  // edge after its transfer. Valid stays high on return, so back-to-back
  // samples keep it high; whoever stops sending drops it.
  task automatic send_sample(input sample_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid  = 1'b0;
      smp.sample = sample_t'($urandom);
      @(negedge clk);
    end
    smp.valid  = 1'b1;
    smp.sample = value;
    do begin
      @(posedge clk);
    end while (!smp.ready);
    @(negedge clk);
  endtask

  // Stops offering samples and waits until every predicted result has been
  // transferred, which leaves the filter idle.
  task automatic drain_results();
    smp.valid  = 1'b0;
    smp.sample = sample_t'($urandom);
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes both registers on back-to-back cycles, in either order. The data
  // words may carry bits above the register width; the filter drops them.
  task automatic apply_setting(input logic [CFG_DATA_WIDTH-1:0] kind_word,
                               input logic [CFG_DATA_WIDTH-1:0] rate_word,
                               input bit kind_first);
    drain_results();
    cfg_write = 1'b1;
    cfg_index = kind_first ? CFG_FILTER_KIND : CFG_RATE_SELECT;
    cfg_data  = kind_first ? kind_word : rate_word;
    @(negedge clk);
    cfg_index = kind_first ? CFG_RATE_SELECT : CFG_FILTER_KIND;
    cfg_data  = kind_first ? rate_word : kind_word;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = CFG_DATA_WIDTH'($urandom);
  endtask

  // Random samples mix full-scale noise, small signals, rail-to-rail swings
  // and held levels, so the delays both settle and saturate.
  task automatic send_random_set(input int count, input bit pause_midway);
    sample_t level;
    sample_t x;
    level = sample_t'($urandom);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        drain_results();
      end
      if ($urandom_range(7) == 0) begin
        level = sample_t'($urandom);
      end
      case ($urandom_range(3))
        0: x = sample_t'($urandom);
        1: x = sample_t'(int'($urandom_range(1023)) - 512);
        2: x = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        default: x = level;
      endcase
      send_sample(x);
    end
  endtask

  // Directed samples: the field extremes, zero and unit steps.
  sample_t edge_samples [6];

  initial begin
    logic [2:0] set_sel;
    int         set_id;

    edge_samples = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, 16'sd1, -16'sd1, SAMPLE_MAX};

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_FILTER_KIND;
    cfg_data      = '0;
    smp.valid     = 1'b0;
    smp.sample    = '0;
    hold_ready    = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 60;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset setting, the 250 Hz lowpass set, with the extreme samples.
    foreach (edge_samples[i]) begin
      send_sample(edge_samples[i]);
    end

    // The 100 Hz highpass set has both feedback poles at -1, so a
    // rail-to-rail input drives the delays into saturation and the output
    // into clipping. The kind word also carries an excess upper bit.
    apply_setting({1'b1, KIND_HIGHPASS}, RATE_100HZ, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
    end

    // Excess bit set with a low kind bit: lowpass at 1000 Hz.
    apply_setting({1'b1, KIND_LOWPASS}, RATE_1000HZ, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_sample(SAMPLE_MIN);
    end

    // Highpass at 1000 Hz starting from cleared delays overshoots on the
    // first full-scale swings, so alternating samples overflow the output.
    apply_setting({1'b0, KIND_HIGHPASS}, RATE_1000HZ, 1'b1);
    for (int i = 0; i < 4; i++) begin
      send_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN);
    end

    // Three idling phases; the first eight settings walk every coefficient
    // set, the rest are random.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        set_id  = phase * SETS_PER_PHASE + s;
        set_sel = (set_id < 8) ? set_id[2:0] : 3'($urandom);
        apply_setting({1'($urandom), set_sel[2]}, set_sel[1:0], 1'($urandom));
        // With no idling at all, the receiver holds off for a long stretch
        // while samples keep coming, so the filter stalls its input.
        if (phase == 2 && s == 0) begin
          fork
            begin
              hold_ready = 1'b1;
              repeat (HOLD_CYCLES) @(negedge clk);
              hold_ready = 1'b0;
            end
          join_none
        end
        send_random_set(ITEMS_PER_SET, s == 2);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sbq_pkg.sv
hw/rtl/sbq_sample_if.sv
hw/rtl/sbq_result_if.sv
hw/rtl/sbq_mac.sv
hw/rtl/sbq_seq.sv
hw/rtl/selectable_biquad_ecg_filter.sv
hw/rtl/sbq_check.sv
sim/sbq_filter_checker.sv
sim/tb_selectable_biquad_ecg_filter.sv
